FILE: rtl/tolp_pkg.sv
package tolp_pkg;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_BAD_BIG   = 2'd2;

   // Configuration register map (word index)
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam logic        REG_MAX_WIN = 1'b0;
   localparam logic [15:0] MAX_WIN_RST = 16'd64;

   // Character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [7:0] CASE_SHIFT = 8'h20;

   // Key matching
   localparam logic [3:0] BIG_LEN    = 4'd7;
   localparam logic [3:0] WIN_LEN    = 4'd10;
   localparam logic [3:0] MATCH_FAIL = 4'd15;

   // Number accumulator saturation point
   localparam logic [16:0] ACCUM_CAP = 17'h10000;
   localparam logic [15:0] WIN_NONE  = 16'd1;

   // Parser phase
   typedef enum logic [2:0] {
      PH_KEY       = 3'b001,
      PH_VAL_START = 3'b010,
      PH_VAL_BODY  = 3'b100
   } phase_type;

   // Kind of value being read
   typedef enum logic [2:0] {
      KIND_OTHER   = 3'b001,
      KIND_BIGFILE = 3'b010,
      KIND_WINDOW  = 3'b100
   } kind_type;

   // Bigfile value progress
   typedef enum logic [2:0] {
      BV_EMPTY = 3'b001,
      BV_ONE   = 3'b010,
      BV_BAD   = 3'b100
   } bv_type;

   // Number scan progress
   typedef enum logic [2:0] {
      NUM_SPACE  = 3'b001,
      NUM_DIGITS = 3'b010,
      NUM_DONE   = 3'b100
   } num_type;

   // Result passed from the parser to the output register
   typedef struct packed {
      logic [1:0]  status;
      logic        bigfile_on;
      logic [15:0] window_size;
   } result_type;

   function automatic logic [7:0] big_key_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = 8'h62; // b
         4'd1:    ch = 8'h69; // i
         4'd2:    ch = 8'h67; // g
         4'd3:    ch = 8'h66; // f
         4'd4:    ch = 8'h69; // i
         4'd5:    ch = 8'h6C; // l
         4'd6:    ch = 8'h65; // e
         default: ch = CHAR_NUL;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] win_key_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = 8'h77; // w
         4'd1:    ch = 8'h69; // i
         4'd2:    ch = 8'h6E; // n
         4'd3:    ch = 8'h64; // d
         4'd4:    ch = 8'h6F; // o
         4'd5:    ch = 8'h77; // w
         4'd6:    ch = 8'h73; // s
         4'd7:    ch = 8'h69; // i
         4'd8:    ch = 8'h7A; // z
         4'd9:    ch = 8'h65; // e
         default: ch = CHAR_NUL;
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/tftp_option_list_parser_core.sv
// Channel  | Direction | Ports                                   | Transfer
// req      | in        | req_data_byte, req_has_byte, req_last   | req_valid && req_ready
// rsp      | out       | rsp_status, rsp_bigfile_on, rsp_window_size | rsp_valid && rsp_ready
// csr      | in/out    | csr_psel .. csr_prdata (APB)            | psel && penable && pready
//
// One transaction per cycle is sustained while a final byte's result can enter the result register;
// a byte is held in the input register, and a final byte's result is loaded into the result register.
// The parser state update is combinational logic fed back through its own state registers.
// Only a transaction marked last yields a result; others never stall on rsp.
// Reset is synchronous and returns the parser to the start of a packet.
module tftp_option_list_parser_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_has_byte,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_bigfile_on,
   output logic [15:0]                       rsp_window_size,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tolp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 has_ff, has_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tolp_pkg::result_type rsp_ff, rsp_in;
   tolp_pkg::result_type result;
   logic                 advance;
   logic [15:0]          max_window;

   tolp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .max_window_o (max_window)
   );

   // Process the held byte unless its result has nowhere to go
   assign advance   = in_valid_ff && (!last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   tolp_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .step_i       (advance),
      .data_byte_i  (byte_ff),
      .has_byte_i   (has_ff),
      .last_i       (last_ff),
      .max_window_i (max_window),
      .result_o     (result)
   );

   // Input register: load on each accepted transaction
   always_comb begin
      in_valid_in = in_valid_ff;
      byte_in     = byte_ff;
      has_in      = has_ff;
      last_in     = last_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         byte_in     = req_data_byte;
         has_in      = req_has_byte;
         last_in     = req_last;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register: load on a final byte, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance && last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      has_ff  <= has_in;
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_bigfile_on  = rsp_ff.bigfile_on;
   assign rsp_window_size = rsp_ff.window_size;

endmodule

FILE: rtl/tolp_csr.sv
module tolp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tolp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready,
   output logic [15:0]                        max_window_o
);

   logic [15:0] max_window_ff;
   logic [15:0] max_window_in;
   logic        wr_en;
   logic        sel_max_win;

   assign csr_pready  = 1'b1;
   assign sel_max_win = (csr_paddr[tolp_pkg::CSR_ADDR_W-1] == tolp_pkg::REG_MAX_WIN);
   assign wr_en       = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Write the window limit on the access phase
   always_comb begin
      max_window_in = max_window_ff;
      if (wr_en && sel_max_win) begin
         max_window_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_window_ff <= tolp_pkg::MAX_WIN_RST;
      end else begin
         max_window_ff <= max_window_in;
      end
   end

   // Read back
   assign csr_prdata   = sel_max_win ? {16'd0, max_window_ff} : 32'd0;
   assign max_window_o = max_window_ff;

endmodule

FILE: rtl/tolp_parse.sv
module tolp_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_i,
   input  logic [7:0]             data_byte_i,
   input  logic                   has_byte_i,
   input  logic                   last_i,
   input  logic [15:0]            max_window_i,
   output tolp_pkg::result_type   result_o
);

   tolp_pkg::phase_type phase_ff, phase_in;
   tolp_pkg::kind_type  kind_ff, kind_in;
   tolp_pkg::bv_type    bv_ff, bv_in;
   tolp_pkg::num_type   num_ff, num_in;
   logic                key_nonempty_ff, key_nonempty_in;
   logic [3:0]          big_pos_ff, big_pos_in;
   logic [3:0]          win_pos_ff, win_pos_in;
   logic                neg_ff, neg_in;
   logic [16:0]         accum_ff, accum_in;
   logic                bigfile_ff, bigfile_in;
   logic [15:0]         window_ff, window_in;
   logic [1:0]          error_ff, error_in;

   logic [7:0]          lc;
   logic                is_space;
   logic                is_sign;
   logic                is_digit;
   logic [3:0]          digit;
   logic [19:0]         accum_x10;
   logic [16:0]         accum_sat;
   logic                win_ok;
   logic                clean;
   tolp_pkg::num_type   num_cur;
   logic                num_skip;

   // Byte classification
   always_comb begin
      lc = data_byte_i;
      if (data_byte_i >= tolp_pkg::CHAR_UC_A && data_byte_i <= tolp_pkg::CHAR_UC_Z) begin
         lc = data_byte_i + tolp_pkg::CASE_SHIFT;
      end
   end

   assign is_space = (data_byte_i == tolp_pkg::CHAR_SPACE) ||
                     (data_byte_i >= tolp_pkg::CHAR_TAB && data_byte_i <= tolp_pkg::CHAR_CR);
   assign is_sign  = (data_byte_i == tolp_pkg::CHAR_PLUS) ||
                     (data_byte_i == tolp_pkg::CHAR_MINUS);
   assign is_digit = (data_byte_i >= tolp_pkg::CHAR_ZERO) &&
                     (data_byte_i <= tolp_pkg::CHAR_NINE);
   assign digit    = 4'(data_byte_i - tolp_pkg::CHAR_ZERO);

   // Decimal accumulate: times ten by shift and add, then saturate
   assign accum_x10 = ({3'd0, accum_ff} << 3) + ({3'd0, accum_ff} << 1) + {16'd0, digit};
   assign accum_sat = (accum_x10 > {3'd0, tolp_pkg::ACCUM_CAP}) ? tolp_pkg::ACCUM_CAP
                                                                 : accum_x10[16:0];

   assign win_ok = !neg_ff && (accum_ff != 17'd0) && (accum_ff <= {1'b0, max_window_i});

   // Per-byte update, result and end-of-packet clear
   always_comb begin
      phase_in        = phase_ff;
      kind_in         = kind_ff;
      bv_in           = bv_ff;
      num_in          = num_ff;
      key_nonempty_in = key_nonempty_ff;
      big_pos_in      = big_pos_ff;
      win_pos_in      = win_pos_ff;
      neg_in          = neg_ff;
      accum_in        = accum_ff;
      bigfile_in      = bigfile_ff;
      window_in       = window_ff;
      error_in        = error_ff;
      num_cur         = num_ff;
      num_skip        = 1'b0;
      clean           = 1'b0;
      result_o        = '0;

      if (step_i && has_byte_i && error_ff == tolp_pkg::ST_OK) begin
         unique case (phase_ff)
            tolp_pkg::PH_KEY: begin
               if (data_byte_i == tolp_pkg::CHAR_NUL) begin
                  // Key terminated: pick the value handler
                  if (big_pos_ff == tolp_pkg::BIG_LEN) begin
                     kind_in = tolp_pkg::KIND_BIGFILE;
                  end else if (win_pos_ff == tolp_pkg::WIN_LEN) begin
                     kind_in = tolp_pkg::KIND_WINDOW;
                  end else begin
                     kind_in = tolp_pkg::KIND_OTHER;
                  end
                  phase_in = tolp_pkg::PH_VAL_START;
               end else begin
                  // Advance both key matchers
                  key_nonempty_in = 1'b1;
                  if (big_pos_ff >= tolp_pkg::BIG_LEN ||
                      lc != tolp_pkg::big_key_char(big_pos_ff)) begin
                     big_pos_in = tolp_pkg::MATCH_FAIL;
                  end else begin
                     big_pos_in = big_pos_ff + 4'd1;
                  end
                  if (win_pos_ff >= tolp_pkg::WIN_LEN ||
                      lc != tolp_pkg::win_key_char(win_pos_ff)) begin
                     win_pos_in = tolp_pkg::MATCH_FAIL;
                  end else begin
                     win_pos_in = win_pos_ff + 4'd1;
                  end
               end
            end
            tolp_pkg::PH_VAL_START, tolp_pkg::PH_VAL_BODY: begin
               if (data_byte_i == tolp_pkg::CHAR_NUL) begin
                  // Value terminated: commit, or flag a bad bigfile value
                  if (kind_ff == tolp_pkg::KIND_BIGFILE && bv_ff != tolp_pkg::BV_ONE) begin
                     error_in = tolp_pkg::ST_BAD_BIG;
                  end else begin
                     if (kind_ff == tolp_pkg::KIND_BIGFILE) begin
                        bigfile_in = 1'b1;
                     end
                     if (kind_ff == tolp_pkg::KIND_WINDOW && win_ok) begin
                        window_in = accum_ff[15:0];
                     end
                     phase_in        = tolp_pkg::PH_KEY;
                     key_nonempty_in = 1'b0;
                     big_pos_in      = 4'd0;
                     win_pos_in      = 4'd0;
                     kind_in         = tolp_pkg::KIND_OTHER;
                     bv_in           = tolp_pkg::BV_EMPTY;
                     num_in          = tolp_pkg::NUM_SPACE;
                     neg_in          = 1'b0;
                     accum_in        = 17'd0;
                  end
               end else begin
                  phase_in = tolp_pkg::PH_VAL_BODY;
                  unique case (kind_ff)
                     tolp_pkg::KIND_BIGFILE: begin
                        if (bv_ff == tolp_pkg::BV_EMPTY && data_byte_i == tolp_pkg::CHAR_ONE) begin
                           bv_in = tolp_pkg::BV_ONE;
                        end else begin
                           bv_in = tolp_pkg::BV_BAD;
                        end
                     end
                     tolp_pkg::KIND_WINDOW: begin
                        // Skip leading space, take a sign, then digits
                        if (num_ff == tolp_pkg::NUM_SPACE) begin
                           if (is_space) begin
                              num_skip = 1'b1;
                           end else if (is_sign) begin
                              neg_in   = (data_byte_i == tolp_pkg::CHAR_MINUS);
                              num_in   = tolp_pkg::NUM_DIGITS;
                              num_skip = 1'b1;
                           end else begin
                              num_cur = tolp_pkg::NUM_DIGITS;
                           end
                        end
                        if (!num_skip && num_cur == tolp_pkg::NUM_DIGITS) begin
                           if (is_digit) begin
                              accum_in = accum_sat;
                              num_in   = tolp_pkg::NUM_DIGITS;
                           end else begin
                              num_in = tolp_pkg::NUM_DONE;
                           end
                        end
                     end
                     tolp_pkg::KIND_OTHER: begin
                        // Unknown option: ignore the value
                     end
                     default: begin
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end

      // Result on the final transaction of a packet
      clean = (phase_in == tolp_pkg::PH_KEY || phase_in == tolp_pkg::PH_VAL_START) &&
              !key_nonempty_in;
      if (error_in != tolp_pkg::ST_OK) begin
         result_o.status = error_in;
      end else if (clean) begin
         result_o.status = tolp_pkg::ST_OK;
      end else begin
         result_o.status = tolp_pkg::ST_MALFORMED;
      end
      result_o.bigfile_on  = (result_o.status == tolp_pkg::ST_OK) ? bigfile_in : 1'b0;
      result_o.window_size = (result_o.status == tolp_pkg::ST_OK) ? window_in
                                                                   : tolp_pkg::WIN_NONE;

      // Clear everything for the next packet
      if (step_i && last_i) begin
         phase_in        = tolp_pkg::PH_KEY;
         key_nonempty_in = 1'b0;
         big_pos_in      = 4'd0;
         win_pos_in      = 4'd0;
         kind_in         = tolp_pkg::KIND_OTHER;
         bv_in           = tolp_pkg::BV_EMPTY;
         num_in          = tolp_pkg::NUM_SPACE;
         neg_in          = 1'b0;
         accum_in        = 17'd0;
         bigfile_in      = 1'b0;
         window_in       = tolp_pkg::WIN_NONE;
         error_in        = tolp_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= tolp_pkg::PH_KEY;
         kind_ff         <= tolp_pkg::KIND_OTHER;
         bv_ff           <= tolp_pkg::BV_EMPTY;
         num_ff          <= tolp_pkg::NUM_SPACE;
         key_nonempty_ff <= 1'b0;
         big_pos_ff      <= 4'd0;
         win_pos_ff      <= 4'd0;
         neg_ff          <= 1'b0;
         accum_ff        <= 17'd0;
         bigfile_ff      <= 1'b0;
         window_ff       <= tolp_pkg::WIN_NONE;
         error_ff        <= tolp_pkg::ST_OK;
      end else begin
         phase_ff        <= phase_in;
         kind_ff         <= kind_in;
         bv_ff           <= bv_in;
         num_ff          <= num_in;
         key_nonempty_ff <= key_nonempty_in;
         big_pos_ff      <= big_pos_in;
         win_pos_ff      <= win_pos_in;
         neg_ff          <= neg_in;
         accum_ff        <= accum_in;
         bigfile_ff      <= bigfile_in;
         window_ff       <= window_in;
         error_ff        <= error_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step_i && last_i |=> phase_ff == tolp_pkg::PH_KEY && !key_nonempty_ff &&
                           error_ff == tolp_pkg::ST_OK && window_ff == tolp_pkg::WIN_NONE)
      else $error("parser state not cleared after final transaction");

   a_window_nonzero: assert property (@(posedge clock) disable iff (reset)
      window_ff != 16'd0)
      else $error("stored window size is zero");

   a_no_stored_malformed: assert property (@(posedge clock) disable iff (reset)
      error_ff != tolp_pkg::ST_MALFORMED)
      else $error("malformed status latched mid-packet");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      step_i && last_i && result_o.status != tolp_pkg::ST_OK |->
         !result_o.bigfile_on && result_o.window_size == tolp_pkg::WIN_NONE)
      else $error("error result carries option values");
`endif

endmodule
